/* hdl/radix_digit_emitter_defines.svh */
// assertion macros for the radix digit emitter checker
// no dependencies; included by files that hold concurrent assertions
`ifndef RADIX_DIGIT_EMITTER_DEFINES_SVH
`define RADIX_DIGIT_EMITTER_DEFINES_SVH

// same-cycle implication, off during reset
`define RDE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define RDE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/rde_pkg.sv */
// shared constants, types and the digit-to-ascii function
// no dependencies; used by every module of the radix digit emitter
package rde_pkg;

    localparam int VALUE_BITS_DEF = 31;
    localparam int RADIX_BITS     = 5;
    localparam int DIGIT_BITS     = 4;
    localparam int CHAR_BITS      = 7;

    localparam logic [RADIX_BITS-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_BITS-1:0] RADIX_MAX = 5'd16;

    localparam logic [DIGIT_BITS-1:0] DIGIT_TEN = 4'd10;
    localparam logic [CHAR_BITS-1:0]  ASC_ZERO  = 7'd48;
    localparam logic [CHAR_BITS-1:0]  ASC_A     = 7'd65;
    localparam logic [CHAR_BITS-1:0]  CHAR_NONE = 7'd0;

    // controller to datapath
    typedef struct packed {
        logic load;      // take a new value and radix
        logic load_bad;  // load the flagged single result
        logic step;      // one restoring divide step
        logic push;      // push remainder digit, clear remainder
        logic pop;       // move top digit to the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_bad;    // incoming radix outside 2..16
        logic quo_zero;  // quotient register is zero
        logic out_last;  // output register holds the final digit
    } t_sts;

    function automatic logic [CHAR_BITS-1:0] digit_ascii(input logic [DIGIT_BITS-1:0] d);
        logic [DIGIT_BITS-1:0] ofs;
        ofs = d - DIGIT_TEN;
        if (d < DIGIT_TEN) begin
            return ASC_ZERO + {{(CHAR_BITS-DIGIT_BITS){1'b0}}, d};
        end else begin
            return ASC_A + {{(CHAR_BITS-DIGIT_BITS){1'b0}}, ofs};
        end
    endfunction

endpackage

/* hdl/rde_ctrl.sv */
// controller state machine for the radix digit emitter
// depends on rde_pkg (t_cmd, t_sts)
module rde_ctrl #(
    parameter int VALUE_BITS = rde_pkg::VALUE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    input  rde_pkg::t_sts i_sts,
    output rde_pkg::t_cmd o_cmd
);

    localparam int CNT_W = $clog2(VALUE_BITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_PUSH,
        ST_POP,
        ST_HOLD
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_valid;
    logic              r_stall;
    logic              accept;

    assign accept  = i_valid && !r_stall;
    assign o_stall = r_stall;
    assign o_valid = r_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == ST_IDLE) && accept;
        o_cmd.load_bad = (r_state == ST_IDLE) && accept && i_sts.in_bad;
        o_cmd.step     = (r_state == ST_DIV);
        o_cmd.push     = (r_state == ST_PUSH);
        o_cmd.pop      = (r_state == ST_POP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
            r_stall <= 1'b1;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_stall <= 1'b1;
                        r_cnt   <= '0;
                        if (i_sts.in_bad) begin
                            r_valid <= 1'b1;
                            r_state <= ST_HOLD;
                        end else begin
                            r_state <= ST_DIV;
                        end
                    end else begin
                        r_stall <= 1'b0;
                    end
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(VALUE_BITS - 1)) begin
                        r_state <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    r_cnt <= '0;
                    if (i_sts.quo_zero) begin
                        r_state <= ST_POP;
                    end else begin
                        r_state <= ST_DIV;
                    end
                end
                ST_POP: begin
                    r_valid <= 1'b1;
                    r_state <= ST_HOLD;
                end
                ST_HOLD: begin
                    if (!i_stall) begin
                        r_valid <= 1'b0;
                        if (i_sts.out_last) begin
                            r_stall <= 1'b0;
                            r_state <= ST_IDLE;
                        end else begin
                            r_state <= ST_POP;
                        end
                    end
                end
                default: begin
                    r_valid <= 1'b0;
                    r_stall <= 1'b1;
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* hdl/rde_dpath.sv */
// datapath: bit-serial divider, digit stack and output register
// depends on rde_pkg (constants, t_cmd, t_sts, digit_ascii)
module rde_dpath #(
    parameter int VALUE_BITS = rde_pkg::VALUE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [VALUE_BITS-1:0]             i_value,
    input  logic [rde_pkg::RADIX_BITS-1:0]    i_radix,
    input  rde_pkg::t_cmd                     i_cmd,
    output rde_pkg::t_sts                     o_sts,
    output logic [rde_pkg::CHAR_BITS-1:0]     o_digit_char,
    output logic                              o_last,
    output logic                              o_bad_radix
);

    localparam int DEPTH_W = $clog2(VALUE_BITS + 1);
    localparam int DB      = rde_pkg::DIGIT_BITS;

    logic [VALUE_BITS-1:0]          r_quo;
    logic [DB-1:0]                  r_rem;
    logic [rde_pkg::RADIX_BITS-1:0] r_rdx;
    logic [DB-1:0]                  r_stack [VALUE_BITS];
    logic [DEPTH_W-1:0]             r_depth;
    logic [rde_pkg::CHAR_BITS-1:0]  r_char;
    logic                           r_last;
    logic                           r_bad;

    logic [DB:0]   rem_sh;
    logic [DB:0]   rem_diff;
    logic          ge;
    logic [DB-1:0] n_rem;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        rem_sh   = {r_rem, r_quo[VALUE_BITS-1]};
        rem_diff = rem_sh - r_rdx;
        ge       = (rem_sh >= r_rdx);
        n_rem    = ge ? rem_diff[DB-1:0] : rem_sh[DB-1:0];
    end

    always_comb begin
        o_sts          = '0;
        o_sts.in_bad   = (i_radix < rde_pkg::RADIX_MIN) || (i_radix > rde_pkg::RADIX_MAX);
        o_sts.quo_zero = (r_quo == '0);
        o_sts.out_last = r_last;
    end

    assign o_digit_char = r_char;
    assign o_last       = r_last;
    assign o_bad_radix  = r_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else if (i_cmd.load) begin
            r_depth <= '0;
        end else if (i_cmd.push) begin
            r_depth <= r_depth + 1'b1;
        end else if (i_cmd.pop) begin
            r_depth <= r_depth - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quo <= i_value;
            r_rdx <= i_radix;
            r_rem <= '0;
        end else if (i_cmd.step) begin
            r_quo <= {r_quo[VALUE_BITS-2:0], ge};
            r_rem <= n_rem;
        end else if (i_cmd.push) begin
            r_rem <= '0;
        end
    end

    // digit stack, top at entry 0
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_stack[0] <= r_rem;
            for (int i = 1; i < VALUE_BITS; i++) begin
                r_stack[i] <= r_stack[i-1];
            end
        end else if (i_cmd.pop) begin
            for (int i = 0; i < VALUE_BITS - 1; i++) begin
                r_stack[i] <= r_stack[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_bad) begin
            r_char <= rde_pkg::CHAR_NONE;
            r_last <= 1'b1;
            r_bad  <= 1'b1;
        end else if (i_cmd.pop) begin
            r_char <= rde_pkg::digit_ascii(r_stack[0]);
            r_last <= (r_depth == DEPTH_W'(1));
            r_bad  <= 1'b0;
        end
    end

endmodule

/* hdl/radix_digit_emitter.sv */
// top level of the radix digit emitter: integer to ascii digits, base 2 to 16
// depends on rde_pkg, rde_ctrl and rde_dpath
//
//   channel | valid   | stall   | payload
//   --------+---------+---------+-------------------------------------
//   input   | i_valid | o_stall | i_value, i_radix
//   output  | o_valid | i_stall | o_digit_char, o_last, o_bad_radix
//
// each digit of an item comes from a bit-serial restoring division over all value
//   bits, one divider step per cycle, plus one push per digit
// each digit is then emitted by a stack pop into the output register
// worst case is base 2 with all value bits used, one digit per value bit
// a bad radix gives its single flagged item in the cycle after acceptance
// synchronous active-low reset; o_stall stays high through reset and in the cycle after it
// a stalled output simply holds; the next item is taken once the last digit leaves
module radix_digit_emitter #(
    parameter int VALUE_BITS = rde_pkg::VALUE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [VALUE_BITS-1:0]          i_value,
    input  logic [rde_pkg::RADIX_BITS-1:0] i_radix,
    // output channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [rde_pkg::CHAR_BITS-1:0]  o_digit_char,
    output logic                           o_last,
    output logic                           o_bad_radix
);

    // commands go down to the datapath, status comes back up
    rde_pkg::t_cmd cmd;
    rde_pkg::t_sts sts;

    // sequencer: divide loop per digit, then pop digits most significant first
    rde_ctrl #(
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // quotient/remainder registers, lifo of remainders, output item register
    rde_dpath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_value      (i_value),
        .i_radix      (i_radix),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_digit_char (o_digit_char),
        .o_last       (o_last),
        .o_bad_radix  (o_bad_radix)
    );

endmodule

/* hdl/rde_chk.sv */
// port-level checker for the radix digit emitter, bound to the top level
// depends on rde_pkg and radix_digit_emitter_defines.svh
`include "radix_digit_emitter_defines.svh"

module rde_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [rde_pkg::CHAR_BITS-1:0] o_digit_char,
    input logic                          o_last,
    input logic                          o_bad_radix
);

    logic                            out_bad;
    logic                            bad_bare;
    logic                            out_norm;
    logic                            char_hex;
    logic                            in_take;
    logic                            out_wait;
    logic [rde_pkg::CHAR_BITS+1:0]   out_word;

    assign out_bad  = o_valid && o_bad_radix;
    assign bad_bare = o_last && (o_digit_char == rde_pkg::CHAR_NONE);
    assign out_norm = o_valid && !o_bad_radix;
    // '0'..'9' or 'A'..'F'
    assign char_hex = ((o_digit_char >= rde_pkg::ASC_ZERO) && (o_digit_char <= 7'd57))
                   || ((o_digit_char >= rde_pkg::ASC_A) && (o_digit_char <= 7'd70));
    assign in_take  = i_valid && !o_stall;
    assign out_wait = o_valid && i_stall;
    assign out_word = {o_digit_char, o_last, o_bad_radix};

    // a flagged item is single and carries no character
    `RDE_ASSERT_IMPLY(a_bad_single, i_clk, i_rst_n, out_bad, bad_bare, "bad radix item not bare")

    // a normal item carries a hex digit character
    `RDE_ASSERT_IMPLY(a_char_range, i_clk, i_rst_n, out_norm, char_hex, "digit char out of range")

    // busy right after an input item is taken
    `RDE_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, in_take, o_stall, "not busy after input")

    // stalled output item holds
    `RDE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_wait, o_valid && $stable(out_word), "item moved")

endmodule

bind radix_digit_emitter rde_chk u_rde_chk (.*);
